// File: src/ctap_pkg.sv
// ctap_pkg: types and constants shared by the constant-turn arc propagator.
// No dependencies; compile first.
`timescale 1ns / 1ps
package ctap_pkg;

  localparam int unsigned CFG_AW = 4;

  localparam logic [1:0] REG_COS   = 2'd0;
  localparam logic [1:0] REG_SIN   = 2'd1;
  localparam logic [1:0] REG_STEP  = 2'd2;
  localparam logic [1:0] REG_CLIMB = 2'd3;

  localparam logic [15:0] COS_RESET   = 16'd16384;
  localparam logic [15:0] SIN_RESET   = 16'd0;
  localparam logic [30:0] STEP_RESET  = 31'd1000;
  localparam logic [31:0] CLIMB_RESET = 32'd0;

  // Q14 rounding: half away from zero, as an offset before the arithmetic shift
  localparam logic [63:0] Q14_RND_POS = 64'd8192;
  localparam logic [63:0] Q14_RND_NEG = 64'd8191;

  // mm per metre and ms per second share the same divisor
  localparam logic [31:0] MM_PER_M = 32'd1000;
  localparam logic [9:0]  DIV_K    = 10'd1000;
  localparam logic [63:0] DIV_HALF = 64'd500;

  typedef struct packed {
    logic [15:0] half_turn_cos;
    logic [15:0] half_turn_sin;
    logic [30:0] step_length_ms;
    logic [31:0] climb_rate;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_MUL,
    ST_ROT_MUL,
    ST_ROT_SUM,
    ST_ROT_FIN,
    ST_TRV_MUL,
    ST_TRV_DIV,
    ST_MET_DIV,
    ST_OUT
  } state_t;

endpackage

// File: src/ctap_if.sv
// ctap_if: valid/ready channel interfaces for input items and result items.
// No dependencies.
`timescale 1ns / 1ps
interface ctap_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] start_north;
  logic [31:0] start_east;
  logic [31:0] start_up;
  logic [31:0] start_vel_north;
  logic [31:0] start_vel_east;

  modport source (output valid, req_type, start_north, start_east, start_up,
                  start_vel_north, start_vel_east, input ready);
  modport sink (input valid, req_type, start_north, start_east, start_up,
                start_vel_north, start_vel_east, output ready);
endinterface

interface ctap_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_north;
  logic [31:0] pos_east;
  logic [31:0] pos_up;

  modport source (output valid, pos_north, pos_east, pos_up, input ready);
  modport sink (input valid, pos_north, pos_east, pos_up, output ready);
endinterface

// File: src/ctap_cfg.sv
// ctap_cfg: APB-style register file for turn, step length and climb rate.
// Depends on ctap_pkg.
`timescale 1ns / 1ps
module ctap_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ctap_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output ctap_pkg::cfg_t             cfg
);

  ctap_pkg::cfg_t cfg_r;
  logic [1:0]     reg_idx;

  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_turn_cos  <= ctap_pkg::COS_RESET;
      cfg_r.half_turn_sin  <= ctap_pkg::SIN_RESET;
      cfg_r.step_length_ms <= ctap_pkg::STEP_RESET;
      cfg_r.climb_rate     <= ctap_pkg::CLIMB_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        ctap_pkg::REG_COS:   cfg_r.half_turn_cos  <= pwdata[15:0];
        ctap_pkg::REG_SIN:   cfg_r.half_turn_sin  <= pwdata[15:0];
        ctap_pkg::REG_STEP:  cfg_r.step_length_ms <= pwdata[30:0];
        ctap_pkg::REG_CLIMB: cfg_r.climb_rate     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ctap_pkg::REG_COS:   prdata = {16'd0, cfg_r.half_turn_cos};
      ctap_pkg::REG_SIN:   prdata = {16'd0, cfg_r.half_turn_sin};
      ctap_pkg::REG_STEP:  prdata = {1'b0, cfg_r.step_length_ms};
      ctap_pkg::REG_CLIMB: prdata = cfg_r.climb_rate;
      default:             prdata = 32'd0;
    endcase
  end

endmodule

// File: src/ctap_smul.sv
// ctap_smul: serial signed 32x32 multiplier, one multiplier bit per cycle.
// Depends on nothing; result valid in the cycle done is high.
`timescale 1ns / 1ps
module ctap_smul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  output logic        done,
  output logic [63:0] prod
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic        neg_r;
  logic [63:0] mcand_r;
  logic [31:0] mplier_r;
  logic [63:0] acc_r;
  logic [63:0] acc_nxt;
  logic [31:0] a_mag;
  logic [31:0] b_mag;

  assign a_mag   = op_a[31] ? (32'd0 - op_a) : op_a;
  assign b_mag   = op_b[31] ? (32'd0 - op_b) : op_b;
  assign acc_nxt = mplier_r[0] ? (acc_r + mcand_r) : acc_r;
  assign done    = done_r;
  assign prod    = neg_r ? (64'd0 - acc_r) : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r    <= op_a[31] ^ op_b[31];
      mcand_r  <= {32'd0, a_mag};
      mplier_r <= b_mag;
      acc_r    <= 64'd0;
    end else if (busy_r) begin
      acc_r    <= acc_nxt;
      mcand_r  <= {mcand_r[62:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[31:1]};
    end
  end

endmodule

// File: src/ctap_sdiv.sv
// ctap_sdiv: serial signed divide by 1000, rounding half away from zero.
// Restoring division, one quotient bit per cycle; depends on ctap_pkg.
`timescale 1ns / 1ps
module ctap_sdiv (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dvd,
  output logic        done,
  output logic [63:0] quo
);

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic        neg_r;
  logic [63:0] q_r;
  logic [9:0]  rem_r;
  logic [10:0] trial;
  logic        ge;
  logic [10:0] rem_nxt;
  logic [63:0] q_init;

  // magnitude plus half divisor in one add: ~x + 1 + 500 for negatives
  assign q_init  = (dvd[63] ? ~dvd : dvd) +
                   (dvd[63] ? (ctap_pkg::DIV_HALF + 64'd1) : ctap_pkg::DIV_HALF);
  assign trial   = {rem_r, q_r[63]};
  assign ge      = trial >= {1'b0, ctap_pkg::DIV_K};
  assign rem_nxt = ge ? (trial - {1'b0, ctap_pkg::DIV_K}) : trial;
  assign done    = done_r;
  assign quo     = neg_r ? (64'd0 - q_r) : q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dvd[63];
      q_r   <= q_init;
      rem_r <= 10'd0;
    end else if (busy_r) begin
      rem_r <= rem_nxt[9:0];
      q_r   <= {q_r[62:0], ge};
    end
  end

endmodule

// File: src/constant_turn_arc_propagator_top.sv
// constant_turn_arc_propagator_top: sequencer, state and datapath of the arc propagator.
// Depends on ctap_pkg, ctap_if, ctap_cfg, ctap_smul and ctap_sdiv.
//
// Usage:
//   in_ch takes one item at a time (valid/ready). req_type 0 loads position
//   (metres, kept as mm) and horizontal velocity (mm/s); req_type 1 advances
//   one step: half-turn rotation, integration over step_length_ms, second
//   half-turn rotation. Every item yields one result item on out_ch: the
//   position rounded to metres.
//   The APB-style cfg_ port holds the Q14 half-turn cosine and sine, the step
//   length and the climb rate; write it only while the block is idle.
// Sequencing:
//   One serial multiplier (one bit a cycle) and one serial divide-by-1000
//   unit do all the work. A load item needs three products and three
//   divides, a step item (two rotations of four products, three travel
//   products and divides, three metre divides) eleven products and six
//   divides. The block passes through idle after the result handshake and
//   takes the next item there.
//   in_ch.ready is high only while no item is in work.
// Reset: rst_n (synchronous, active low) clears velocity and position to
//   zero and loads the register defaults. A stalled out_ch holds the result
//   and the block takes no new item until it is taken.
`timescale 1ns / 1ps
module constant_turn_arc_propagator_top (
  input  logic                        clk,
  input  logic                        rst_n,
  ctap_in_if.sink                     in_ch,
  ctap_out_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [ctap_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  ctap_pkg::cfg_t   cfg;
  ctap_pkg::state_t state_r, state_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        pass_r, pass_nxt;
  logic        issued_r;

  // model state
  logic [31:0] vel_n_r, vel_e_r;
  logic [63:0] north_acc_r, east_acc_r, up_acc_r;

  // working registers
  logic [31:0] ld_n_r, ld_e_r, ld_u_r;
  logic [63:0] prod0_r, prod1_r, prod2_r, prod3_r;
  logic [63:0] sum_n_r, sum_e_r;
  logic [31:0] pos_n_r, pos_e_r, pos_u_r;

  logic        mul_start, mul_done;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_prod;
  logic        div_start, div_done;
  logic [63:0] div_dvd, div_quo;
  logic [63:0] acc_sel;
  logic [63:0] rnd_n, rnd_e;
  logic        in_acc;

  assign cfg_pready = 1'b1;

  ctap_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  ctap_smul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  ctap_sdiv u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd   (div_dvd),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign in_ch.ready      = (state_r == ctap_pkg::ST_IDLE);
  assign in_acc           = in_ch.valid && in_ch.ready;
  assign out_ch.valid     = (state_r == ctap_pkg::ST_OUT);
  assign out_ch.pos_north = pos_n_r;
  assign out_ch.pos_east  = pos_e_r;
  assign out_ch.pos_up    = pos_u_r;

  // launch each unit once per operation (per index) in a multiply or divide state
  assign mul_start = !issued_r && (state_r == ctap_pkg::ST_LOAD_MUL ||
                                   state_r == ctap_pkg::ST_ROT_MUL ||
                                   state_r == ctap_pkg::ST_TRV_MUL);
  assign div_start = !issued_r && (state_r == ctap_pkg::ST_TRV_DIV ||
                                   state_r == ctap_pkg::ST_MET_DIV);

  // Q14 round half away from zero, then keep 32 bits of the shifted value
  assign rnd_n = sum_n_r + (sum_n_r[63] ? ctap_pkg::Q14_RND_NEG : ctap_pkg::Q14_RND_POS);
  assign rnd_e = sum_e_r + (sum_e_r[63] ? ctap_pkg::Q14_RND_NEG : ctap_pkg::Q14_RND_POS);

  always_comb begin
    case (idx_r)
      2'd0:    acc_sel = north_acc_r;
      2'd1:    acc_sel = east_acc_r;
      default: acc_sel = up_acc_r;
    endcase
  end

  // multiplier operands
  always_comb begin
    mul_a = vel_n_r;
    mul_b = {1'b0, cfg.step_length_ms};
    case (state_r)
      ctap_pkg::ST_LOAD_MUL: begin
        mul_b = ctap_pkg::MM_PER_M;
        case (idx_r)
          2'd0:    mul_a = ld_n_r;
          2'd1:    mul_a = ld_e_r;
          default: mul_a = ld_u_r;
        endcase
      end
      ctap_pkg::ST_ROT_MUL: begin
        case (idx_r)
          2'd0: begin
            mul_a = vel_n_r;
            mul_b = {{16{cfg.half_turn_cos[15]}}, cfg.half_turn_cos};
          end
          2'd1: begin
            mul_a = vel_e_r;
            mul_b = {{16{cfg.half_turn_sin[15]}}, cfg.half_turn_sin};
          end
          2'd2: begin
            mul_a = vel_n_r;
            mul_b = {{16{cfg.half_turn_sin[15]}}, cfg.half_turn_sin};
          end
          default: begin
            mul_a = vel_e_r;
            mul_b = {{16{cfg.half_turn_cos[15]}}, cfg.half_turn_cos};
          end
        endcase
      end
      ctap_pkg::ST_TRV_MUL: begin
        case (idx_r)
          2'd0:    mul_a = vel_n_r;
          2'd1:    mul_a = vel_e_r;
          default: mul_a = cfg.climb_rate;
        endcase
      end
      default: ;
    endcase
  end

  assign div_dvd = (state_r == ctap_pkg::ST_TRV_DIV) ? prod0_r : acc_sel;

  // next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    pass_nxt  = pass_r;
    case (state_r)
      ctap_pkg::ST_IDLE: begin
        if (in_acc) begin
          idx_nxt   = 2'd0;
          pass_nxt  = 1'b0;
          state_nxt = in_ch.req_type ? ctap_pkg::ST_ROT_MUL : ctap_pkg::ST_LOAD_MUL;
        end
      end
      ctap_pkg::ST_LOAD_MUL: begin
        if (mul_done) begin
          if (idx_r == 2'd2) begin
            idx_nxt   = 2'd0;
            state_nxt = ctap_pkg::ST_MET_DIV;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
      end
      ctap_pkg::ST_ROT_MUL: begin
        if (mul_done) begin
          if (idx_r == 2'd3) begin
            idx_nxt   = 2'd0;
            state_nxt = ctap_pkg::ST_ROT_SUM;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
      end
      ctap_pkg::ST_ROT_SUM: state_nxt = ctap_pkg::ST_ROT_FIN;
      ctap_pkg::ST_ROT_FIN: begin
        idx_nxt = 2'd0;
        if (!pass_r) begin
          pass_nxt  = 1'b1;
          state_nxt = ctap_pkg::ST_TRV_MUL;
        end else begin
          state_nxt = ctap_pkg::ST_MET_DIV;
        end
      end
      ctap_pkg::ST_TRV_MUL: begin
        if (mul_done) state_nxt = ctap_pkg::ST_TRV_DIV;
      end
      ctap_pkg::ST_TRV_DIV: begin
        if (div_done) begin
          if (idx_r == 2'd2) begin
            idx_nxt   = 2'd0;
            state_nxt = ctap_pkg::ST_ROT_MUL;
          end else begin
            idx_nxt   = idx_r + 2'd1;
            state_nxt = ctap_pkg::ST_TRV_MUL;
          end
        end
      end
      ctap_pkg::ST_MET_DIV: begin
        if (div_done) begin
          if (idx_r == 2'd2) begin
            idx_nxt   = 2'd0;
            state_nxt = ctap_pkg::ST_OUT;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
      end
      ctap_pkg::ST_OUT: begin
        if (out_ch.ready) state_nxt = ctap_pkg::ST_IDLE;
      end
      default: state_nxt = ctap_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ctap_pkg::ST_IDLE;
      idx_r    <= 2'd0;
      pass_r   <= 1'b0;
      issued_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      pass_r  <= pass_nxt;
      if (mul_done || div_done) begin
        issued_r <= 1'b0;
      end else if (mul_start || div_start) begin
        issued_r <= 1'b1;
      end
    end
  end

  // velocity and position: the state that persists between items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_n_r     <= 32'd0;
      vel_e_r     <= 32'd0;
      north_acc_r <= 64'd0;
      east_acc_r  <= 64'd0;
      up_acc_r    <= 64'd0;
    end else begin
      case (state_r)
        ctap_pkg::ST_IDLE: begin
          if (in_acc && !in_ch.req_type) begin
            vel_n_r <= in_ch.start_vel_north;
            vel_e_r <= in_ch.start_vel_east;
          end
        end
        ctap_pkg::ST_LOAD_MUL: begin
          if (mul_done) begin
            case (idx_r)
              2'd0:    north_acc_r <= mul_prod;
              2'd1:    east_acc_r  <= mul_prod;
              default: up_acc_r    <= mul_prod;
            endcase
          end
        end
        ctap_pkg::ST_ROT_FIN: begin
          vel_n_r <= rnd_n[45:14];
          vel_e_r <= rnd_e[45:14];
        end
        ctap_pkg::ST_TRV_DIV: begin
          if (div_done) begin
            case (idx_r)
              2'd0:    north_acc_r <= north_acc_r + div_quo;
              2'd1:    east_acc_r  <= east_acc_r + div_quo;
              default: up_acc_r    <= up_acc_r + div_quo;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // working registers: operands, products, sums and the result
  always_ff @(posedge clk) begin
    case (state_r)
      ctap_pkg::ST_IDLE: begin
        if (in_acc) begin
          ld_n_r <= in_ch.start_north;
          ld_e_r <= in_ch.start_east;
          ld_u_r <= in_ch.start_up;
        end
      end
      ctap_pkg::ST_ROT_MUL: begin
        if (mul_done) begin
          case (idx_r)
            2'd0:    prod0_r <= mul_prod;
            2'd1:    prod1_r <= mul_prod;
            2'd2:    prod2_r <= mul_prod;
            default: prod3_r <= mul_prod;
          endcase
        end
      end
      ctap_pkg::ST_ROT_SUM: begin
        sum_n_r <= prod0_r - prod1_r;
        sum_e_r <= prod2_r + prod3_r;
      end
      ctap_pkg::ST_TRV_MUL: begin
        if (mul_done) prod0_r <= mul_prod;
      end
      ctap_pkg::ST_MET_DIV: begin
        if (div_done) begin
          case (idx_r)
            2'd0:    pos_n_r <= div_quo[31:0];
            2'd1:    pos_e_r <= div_quo[31:0];
            default: pos_u_r <= div_quo[31:0];
          endcase
        end
      end
      default: ;
    endcase
  end

endmodule
